FILE: hdl/fcd_pkg.sv
// Shared types and constants for the circular-delay FIR filter.
// No dependencies; used by fir_filter_circular_delay.

package fcd_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_TAPS_DEF    = 128;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEFF_BITS_DEF  = 16;

    // Fixed field widths
    localparam int CFG_W   = 8;   // tap_count register
    localparam int IDX_W   = 7;   // tap_index field
    localparam int DIGIT_W = 4;   // coefficient digit consumed per cycle

    localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(128);

    // Opcodes of an input item
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,   // zero both stores after reset
        S_IDLE,    // take items
        S_READ,    // issue store reads for one tap
        S_LOAD,    // load operand registers from the stores
        S_MAC,     // digit-serial multiply
        S_ACC,     // add product into accumulator
        S_ROUND,   // round and saturate
        S_DONE     // hand result to the output register
    } t_state;

endpackage

FILE: hdl/fcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module fcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/fir_filter_circular_delay.sv
// Top level of the direct-form FIR filter with a circular delay store.
// Depends on fcd_pkg and fcd_ram.

// A sample item (opcode 0) is written into a circular delay store of tap_count
// entries and yields one result: the sum over all active taps of coefficient
// times delayed sample, rounded half up and saturated to SAMPLE_BITS. A load
// item (opcode 1) writes one coefficient and yields nothing, and the block
// stays ready for the next item; loads with tap_index not below MAX_TAPS are
// dropped. Each tap goes through a digit-serial multiplier that consumes
// DIGIT_W coefficient bits per cycle; one tap runs store read, operand load,
// ND digit steps (ND = ceil(COEFF_BITS / 4)) and accumulate. After the last
// tap come round and hand-over, and only then is the block ready again;
// hand-over waits while a result still sits unread in the output register.
// After reset the block zeroes both stores and takes no item meanwhile;
// tap_count writes are accepted at any time but are meant to arrive while
// the block is idle. A finished result sits in an output register, so the
// next item is taken while it waits.

module fir_filter_circular_delay #(
    parameter int MAX_TAPS    = fcd_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = fcd_pkg::COEFF_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  logic [fcd_pkg::IDX_W-1:0]      i_tap_index,
    input  logic signed [COEFF_BITS-1:0]   i_tap_value,
    input  logic                           i_block_end_in,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_BITS-1:0]  o_sample_out,
    output logic                           o_block_end_out,
    // tap_count write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcd_pkg::CFG_W-1:0]      i_cfg_data
);

    // Address and count widths
    localparam int AB  = $clog2(MAX_TAPS);
    localparam int CW  = $clog2(MAX_TAPS + 1);
    localparam int TW  = (CW > fcd_pkg::CFG_W) ? CW : fcd_pkg::CFG_W;
    localparam int XW  = (CW > fcd_pkg::IDX_W) ? CW : fcd_pkg::IDX_W;
    // Digit-serial multiplier
    localparam int DW  = fcd_pkg::DIGIT_W;
    localparam int ND  = (COEFF_BITS + DW - 1) / DW;
    localparam int CPW = ND * DW;
    localparam int DGW = (ND > 1) ? $clog2(ND) : 1;
    localparam int PW  = SAMPLE_BITS + CPW;
    // Accumulator: exact, but capped at 63 bits; saturates at +-(2^(AW-1)-1)
    localparam int NAT = SAMPLE_BITS + COEFF_BITS + AB;
    localparam int AW  = (NAT > 63) ? 63 : NAT;
    localparam int SW  = ((AW > PW) ? AW : PW) + 1;

    localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (AW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX;
    localparam logic signed [AW:0]   RND     = (AW + 1)'(64'sd1 <<< (COEFF_BITS - 2));
    localparam logic signed [AW:0]   Y_MAX   = (AW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [AW:0]   Y_MIN   = -Y_MAX - (AW + 1)'(1);
    localparam logic [AB-1:0]        LAST_ADDR = AB'(MAX_TAPS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fcd_pkg::t_state r_state, n_state;

    logic [fcd_pkg::CFG_W-1:0]     r_tap_count;
    logic [AB-1:0]                 r_clr;        // clearing sweep address
    logic [AB-1:0]                 r_wr_pos;     // next delay write position
    logic [AB-1:0]                 r_last;       // active taps minus one
    logic [AB-1:0]                 r_j;          // coefficient index
    logic [AB-1:0]                 r_k;          // delay index for tap j
    logic [DGW-1:0]                r_dig;        // digit step within a tap
    logic                          r_block_end;
    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic [CPW-1:0]                r_coef;       // digit shift register
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_block_end_out;

    // ------------------------------------------------------------------
    // Store ports
    // ------------------------------------------------------------------
    logic                   w_dly_we, w_coef_we, w_rd_en;
    logic [AB-1:0]          w_dly_wa, w_coef_wa;
    logic [SAMPLE_BITS-1:0] w_dly_wd, w_dly_rd;
    logic [COEFF_BITS-1:0]  w_coef_wd, w_coef_rd;

    fcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_delay_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_dly_we),
        .i_wr_addr (w_dly_wa),
        .i_wr_data (w_dly_wd),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_k),
        .o_rd_data (w_dly_rd)
    );

    fcd_ram #(.WIDTH(COEFF_BITS), .DEPTH(MAX_TAPS)) u_coeff_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_coef_we),
        .i_wr_addr (w_coef_wa),
        .i_wr_data (w_coef_wd),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_j),
        .o_rd_data (w_coef_rd)
    );

    // ------------------------------------------------------------------
    // Item decode: effective tap count, write position, load range check
    // ------------------------------------------------------------------
    logic [TW-1:0] w_taps_cfg;
    logic [AB-1:0] w_last;       // effective taps minus one
    logic [AB-1:0] w_pos;        // position this sample goes to
    logic [AB-1:0] w_pos_next;
    logic          w_idx_ok;
    logic          w_accept, w_take_sample, w_take_load;
    logic          w_slot_free;

    always_comb begin
        w_taps_cfg = TW'(r_tap_count);
        // a count of zero acts as one tap, an oversized one as MAX_TAPS
        if (w_taps_cfg == '0) begin
            w_last = '0;
        end else if (w_taps_cfg > TW'(MAX_TAPS)) begin
            w_last = LAST_ADDR;
        end else begin
            w_last = AB'(w_taps_cfg - TW'(1));
        end
        // restart the ring when the count was lowered to or below the position
        w_pos      = (r_wr_pos > w_last) ? '0 : r_wr_pos;
        w_pos_next = (w_pos == w_last) ? '0 : w_pos + AB'(1);
        w_idx_ok   = XW'(i_tap_index) < XW'(MAX_TAPS);
    end

    assign w_accept      = i_valid && o_ready;
    assign w_take_sample = w_accept && (i_opcode == fcd_pkg::OP_FILTER);
    assign w_take_load   = w_accept && (i_opcode == fcd_pkg::OP_LOAD);
    assign w_slot_free   = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            fcd_pkg::S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = fcd_pkg::S_IDLE;
                end
            end
            fcd_pkg::S_IDLE: begin
                if (w_take_sample) begin
                    n_state = fcd_pkg::S_READ;
                end
            end
            fcd_pkg::S_READ:  n_state = fcd_pkg::S_LOAD;
            fcd_pkg::S_LOAD:  n_state = fcd_pkg::S_MAC;
            fcd_pkg::S_MAC: begin
                if (r_dig == DGW'(ND - 1)) begin
                    n_state = fcd_pkg::S_ACC;
                end
            end
            fcd_pkg::S_ACC: begin
                n_state = (r_j == r_last) ? fcd_pkg::S_ROUND : fcd_pkg::S_READ;
            end
            fcd_pkg::S_ROUND: n_state = fcd_pkg::S_DONE;
            fcd_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_state = fcd_pkg::S_IDLE;
                end
            end
            default: n_state = fcd_pkg::S_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // State-driven controls
    // ------------------------------------------------------------------
    always_comb begin
        o_ready   = 1'b0;
        w_rd_en   = 1'b0;
        w_dly_we  = 1'b0;
        w_dly_wa  = w_pos;
        w_dly_wd  = i_sample_in;
        w_coef_we = 1'b0;
        w_coef_wa = AB'(i_tap_index);
        w_coef_wd = i_tap_value;
        case (r_state)
            fcd_pkg::S_CLEAR: begin
                // zero both stores, one entry per cycle
                w_dly_we  = 1'b1;
                w_dly_wa  = r_clr;
                w_dly_wd  = '0;
                w_coef_we = 1'b1;
                w_coef_wa = r_clr;
                w_coef_wd = '0;
            end
            fcd_pkg::S_IDLE: begin
                o_ready   = 1'b1;
                w_dly_we  = w_take_sample;
                w_coef_we = w_take_load && w_idx_ok;
            end
            fcd_pkg::S_READ: w_rd_en = 1'b1;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    logic signed [DW:0]             w_digit;
    logic signed [SAMPLE_BITS+DW:0] w_dprod;
    logic signed [PW-1:0]           w_prod_next;
    logic signed [SW-1:0]           w_sum;
    logic signed [AW-1:0]           w_acc_next;
    logic signed [AW:0]             w_rounded;
    logic signed [AW:0]             w_shifted;
    logic signed [SAMPLE_BITS-1:0]  w_y;

    always_comb begin
        // Horner step, top digit first; only the top digit carries the sign
        if (r_dig == '0) begin
            w_digit = {r_coef[CPW-1], r_coef[CPW-1 -: DW]};
        end else begin
            w_digit = {1'b0, r_coef[CPW-1 -: DW]};
        end
        w_dprod     = r_samp * w_digit;
        w_prod_next = (r_prod <<< DW) + PW'(w_dprod);

        // accumulate with saturation
        w_sum = SW'(r_acc) + SW'(r_prod);
        if (w_sum > ACC_MAX) begin
            w_acc_next = AW'(ACC_MAX);
        end else if (w_sum < ACC_MIN) begin
            w_acc_next = AW'(ACC_MIN);
        end else begin
            w_acc_next = AW'(w_sum);
        end

        // round half up, then saturate to the sample range
        w_rounded = (AW + 1)'(r_acc) + RND;
        w_shifted = w_rounded >>> (COEFF_BITS - 1);
        if (w_shifted > Y_MAX) begin
            w_y = SAMPLE_BITS'(Y_MAX);
        end else if (w_shifted < Y_MIN) begin
            w_y = SAMPLE_BITS'(Y_MIN);
        end else begin
            w_y = SAMPLE_BITS'(w_shifted);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcd_pkg::S_CLEAR;
            r_tap_count <= fcd_pkg::TAP_COUNT_RST;
            r_clr       <= '0;
            r_wr_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tap_count <= i_cfg_data;
            end
            if (r_state == fcd_pkg::S_CLEAR) begin
                r_clr <= r_clr + AB'(1);
            end
            if (w_take_sample) begin
                r_wr_pos <= w_pos_next;
            end
            if (r_state == fcd_pkg::S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            fcd_pkg::S_IDLE: begin
                if (w_take_sample) begin
                    r_last      <= w_last;
                    r_j         <= '0;
                    r_k         <= w_pos;
                    r_acc       <= '0;
                    r_block_end <= i_block_end_in;
                end
            end
            fcd_pkg::S_LOAD: begin
                r_samp <= $signed(w_dly_rd);
                r_coef <= CPW'($signed(w_coef_rd));
                r_prod <= '0;
                r_dig  <= '0;
            end
            fcd_pkg::S_MAC: begin
                r_prod <= w_prod_next;
                r_coef <= r_coef << DW;
                r_dig  <= r_dig + DGW'(1);
            end
            fcd_pkg::S_ACC: begin
                r_acc <= w_acc_next;
                // advance to the next tap, walking the ring backwards
                r_j   <= r_j + AB'(1);
                r_k   <= (r_k == '0) ? r_last : r_k - AB'(1);
            end
            fcd_pkg::S_ROUND: r_y <= w_y;
            fcd_pkg::S_DONE: begin
                if (w_slot_free) begin
                    r_sample_out    <= r_y;
                    r_block_end_out <= r_block_end;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_block_end_out = r_block_end_out;
    assign o_cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == fcd_pkg::S_DONE)
        else $error("result raised outside the hand-over state");

    a_read_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fcd_pkg::S_READ |-> (r_j <= r_last) && (r_k <= r_last))
        else $error("store read beyond the active taps");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_sample |=> r_state == fcd_pkg::S_READ && r_j == '0)
        else $error("accepted sample did not start the tap walk");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fcd_pkg::S_MAC |-> r_dig <= DGW'(ND - 1))
        else $error("digit counter ran past the coefficient");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcd_pkg::S_DONE && r_out_valid && !i_ready)
            |=> $stable(r_sample_out))
        else $error("waiting result overwritten");

endmodule

FILE: tb/sv/fir_filter_circular_delay_tb.sv
// Self-checking testbench for fir_filter_circular_delay.
// Needs only fcd_pkg and the RTL of the filter; drives a directed table, then random
// phases over many tap_count settings; checks results against a local predictor or typed-in value.
`timescale 1ns / 1ps

module fir_filter_circular_delay_tb;

    localparam int NTAP = fcd_pkg::MAX_TAPS_DEF;
    localparam int SW   = fcd_pkg::SAMPLE_BITS_DEF;
    localparam int CW   = fcd_pkg::COEFF_BITS_DEF;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    // Loads give no result, so allow a short tail after the last result before
    // touching tap_count.
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int REPORT_LIMIT    = 10;
    localparam int LIMIT_CYCLES    = 2_000_000;

    localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) <<< (SW - 1));

    typedef enum logic [1:0] {ROW_FILTER, ROW_LOAD, ROW_TAPS} t_row_kind;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // One line of the directed table: val is the sample, the coefficient or the
    // tap_count value, depending on the kind; want is used only when chk is set.
    typedef struct packed {
        t_row_kind                 kind;
        int                        val;
        logic [fcd_pkg::IDX_W-1:0] idx;
        logic                      be;
        logic                      chk;
        int                        want;
    } t_dir_row;

    typedef struct packed {
        int         taps;
        int         count;
        t_idle_mode mode;
        logic       pressure;
    } t_phase;

    typedef struct {
        logic                      op;
        logic signed [SW-1:0]      smp;
        logic [fcd_pkg::IDX_W-1:0] idx;
        logic signed [CW-1:0]      coef;
        logic                      be;
    } t_fir_item;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 be;
    } t_filt_out;

    localparam int N_DIR   = 28;
    localparam int N_PHASE = 14;

    // ---------------------------------------------------------------------
    // Signals
    // ---------------------------------------------------------------------
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_opcode;
    logic signed [SW-1:0]      i_sample_in;
    logic [fcd_pkg::IDX_W-1:0] i_tap_index;
    logic signed [CW-1:0]      i_tap_value;
    logic                      i_block_end_in;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [SW-1:0]      o_sample_out;
    logic                      o_block_end_out;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [fcd_pkg::CFG_W-1:0] i_cfg_data;

    // ---------------------------------------------------------------------
    // Predictor state: its own copy of both stores, the write pointer and
    // the tap_count register
    // ---------------------------------------------------------------------
    logic signed [SW-1:0]      delay_line [NTAP];
    logic signed [CW-1:0]      coef_bank  [NTAP];
    int unsigned               wr_pos;
    logic [fcd_pkg::CFG_W-1:0] tap_cfg;

    t_filt_out              pending_out [$];

    t_dir_row               dir_tab   [N_DIR];
    t_phase                 phase_tab [N_PHASE];

    int                     send_gap_pct;
    int                     recv_stall_pct;
    int                     cur_phase;
    logic                   hold_req;

    int                     cycle_count;
    int                     n_errors;
    int                     n_results;
    int                     n_samples;
    int                     n_loads;

    // ---------------------------------------------------------------------
    // Block under test
    // ---------------------------------------------------------------------
    fir_filter_circular_delay DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_sample_in     (i_sample_in),
        .i_tap_index     (i_tap_index),
        .i_tap_value     (i_tap_value),
        .i_block_end_in  (i_block_end_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_out    (o_sample_out),
        .o_block_end_out (o_block_end_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Hard stop: a hang anywhere ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_out.size());
            $display("fir_filter_circular_delay regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // A tap_count of 0 behaves as 1; anything above the store depth as the depth.
    function automatic int unsigned taps_in_use(input logic [fcd_pkg::CFG_W-1:0] cfg);
        if (cfg == '0)
            return 1;
        if (int'(cfg) > NTAP)
            return NTAP;
        return int'(cfg);
    endfunction

    // Write one sample into the circular delay line and return the rounded,
    // saturated convolution sum: tap j pairs with the sample j steps back.
    function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
        int unsigned n;
        int unsigned p;
        int unsigned j;
        int unsigned k;
        longint      acc;
        n = taps_in_use(tap_cfg);
        p = wr_pos;
        // restart the pointer when tap_count was lowered to or beneath it
        if (p >= n)
            p = 0;
        delay_line[p] = x;
        acc = 0;
        for (j = 0; j < n; j++) begin
            k = (p + n - j) % n;
            acc += longint'(delay_line[k]) * longint'(coef_bank[j]);
        end
        // round half up, then drop the coefficient fraction bits
        acc = (acc + (longint'(1) <<< (CW - 2))) >>> (CW - 1);
        wr_pos = (p + 1) % n;
        if (acc > OUT_MAX)
            acc = OUT_MAX;
        if (acc < OUT_MIN)
            acc = OUT_MIN;
        return SW'(acc);
    endfunction

    // ---------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_filt_out want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_out.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: sample_out %0d block_end %0b",
                             $realtime, o_sample_out, o_block_end_out);
            end else begin
                want = pending_out.pop_front();
                if (o_sample_out !== want.smp || o_block_end_out !== want.be) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $display({"[%0t] result %0d mismatch: sample_out exp %0d got %0d,",
                                  " block_end exp %0b got %0b"},
                                 $realtime, n_results, want.smp, o_sample_out,
                                 want.be, o_block_end_out);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall at random, and once per pressure phase hold off for a
    // long stretch so that the output register fills and the input backs up
    // ---------------------------------------------------------------------
    initial begin
        int stall_left;
        int held_phase;
        stall_left = 0;
        held_phase = -1;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && cur_phase != held_phase) begin
                held_phase = cur_phase;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // Offer one item, hold it until taken, then advance the predictor.
    // With chk set, the sample result is the value typed into the table.
    task automatic offer_item(input t_fir_item it, input logic chk, input int want);
        t_filt_out exp_out;
        logic signed [SW-1:0] y;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= it.op;
        i_sample_in    <= it.smp;
        i_tap_index    <= it.idx;
        i_tap_value    <= it.coef;
        i_block_end_in <= it.be;
        do
            @(posedge i_clk);
        while (!o_ready);
        if (it.op == fcd_pkg::OP_LOAD) begin
            n_loads++;
            // every 7-bit index lies inside the store, so every load lands
            coef_bank[it.idx] = it.coef;
        end else begin
            n_samples++;
            y = filter_sample(it.smp);
            exp_out.smp = chk ? SW'(want) : y;
            exp_out.be  = it.be;
            pending_out.push_back(exp_out);
        end
    endtask

    // Drop valid and wait until the block has delivered everything and gone quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_taps(input logic [fcd_pkg::CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tap_cfg = v;
    endtask

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_gap_pct = 0;  recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_gap_pct = 45; recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_gap_pct = 0;  recv_stall_pct = 45;
            end
            default: begin
                send_gap_pct = 7;  recv_stall_pct = 7;
            end
        endcase
    endtask

    // Bias towards the extremes and small magnitudes; otherwise any 16-bit word.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // A quarter loads, mostly into active taps; the rest samples with the
    // unused fields left as noise.
    function automatic t_fir_item random_item(input int unsigned n);
        t_fir_item it;
        it.smp  = SW'($urandom);
        it.idx  = fcd_pkg::IDX_W'($urandom);
        it.coef = CW'($urandom);
        it.be   = 1'($urandom_range(1));
        if ($urandom_range(99) < 25) begin
            it.op = fcd_pkg::OP_LOAD;
            if ($urandom_range(3) != 0)
                it.idx = fcd_pkg::IDX_W'($urandom_range(n - 1));
            it.coef = CW'(pick_word());
        end else begin
            it.op  = fcd_pkg::OP_FILTER;
            it.smp = SW'(pick_word());
            it.be  = ($urandom_range(7) == 0);
        end
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        t_fir_item   it;
        t_dir_row    r;
        t_phase      ph;
        int unsigned n;
        int          i;
        int          p;

        // Directed table. Typed-in results only where they follow at a glance:
        // zero coefficients after reset, full-scale products, round half up and
        // the single-tap cases at tap_count 0.
        dir_tab = '{
            '{ROW_FILTER,  32767,   7'd0, 1'b1, 1'b1,      0},  // coefficients cleared
            '{ROW_FILTER, -32768,   7'd0, 1'b0, 1'b1,      0},
            '{ROW_LOAD,   -32768,   7'd0, 1'b1, 1'b0,      0},  // marker on a load ignored
            '{ROW_FILTER, -32768,   7'd0, 1'b0, 1'b1,  32767},  // -1 * -1 saturates
            '{ROW_FILTER,  32767,   7'd0, 1'b1, 1'b1, -32767},
            '{ROW_FILTER,      0,   7'd0, 1'b0, 1'b1,      0},
            '{ROW_LOAD,        1,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_FILTER,  16384,   7'd0, 1'b0, 1'b1,      1},  // exact half rounds up
            '{ROW_FILTER, -16384,   7'd0, 1'b1, 1'b1,      0},  // and towards zero here
            '{ROW_LOAD,    32767, 7'd127, 1'b0, 1'b0,      0},  // top coefficient
            '{ROW_LOAD,    32767,   7'd1, 1'b0, 1'b0,      0},
            '{ROW_FILTER, -32768,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_FILTER, -32768,   7'd0, 1'b1, 1'b0,      0},
            '{ROW_TAPS,        0,   7'd0, 1'b0, 1'b0,      0},  // zero taps act as one
            '{ROW_LOAD,    16384,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_FILTER,   1000,   7'd0, 1'b0, 1'b1,    500},  // pointer restarts at 0
            '{ROW_FILTER,  -1000,   7'd0, 1'b1, 1'b1,   -500},
            '{ROW_TAPS,        3,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_LOAD,   -32768,   7'd2, 1'b0, 1'b0,      0},
            '{ROW_FILTER,  12345,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_FILTER,     -1,   7'd0, 1'b1, 1'b0,      0},
            '{ROW_LOAD,      777,   7'd5, 1'b0, 1'b0,      0},  // stored beyond active taps
            '{ROW_FILTER,  32767,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_TAPS,      255,   7'd0, 1'b0, 1'b0,      0},  // above depth acts as depth
            '{ROW_FILTER,      7,   7'd0, 1'b1, 1'b0,      0},
            '{ROW_TAPS,        6,   7'd0, 1'b0, 1'b0,      0},  // tap 5 now counts
            '{ROW_FILTER, -32768,   7'd0, 1'b0, 1'b0,      0},
            '{ROW_FILTER,    100,   7'd0, 1'b1, 1'b0,      0}
        };

        // Random phases: mostly short filters, a few at full length.
        phase_tab = '{
            '{  0, 60, IDLE_NONE, 1'b0},
            '{  1, 60, IDLE_SEND, 1'b0},
            '{  2, 70, IDLE_RECV, 1'b1},
            '{  5, 80, IDLE_BOTH, 1'b0},
            '{ 16, 80, IDLE_NONE, 1'b0},
            '{  3, 60, IDLE_SEND, 1'b0},
            '{255, 12, IDLE_RECV, 1'b0},
            '{ 12, 80, IDLE_BOTH, 1'b0},
            '{129, 10, IDLE_NONE, 1'b0},
            '{ 31, 60, IDLE_SEND, 1'b0},
            '{ 64, 20, IDLE_RECV, 1'b0},
            '{  7, 80, IDLE_BOTH, 1'b0},
            '{128,  8, IDLE_BOTH, 1'b0},
            '{  9, 60, IDLE_NONE, 1'b0}
        };

        // Hold every input at a known value from time zero.
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = fcd_pkg::OP_FILTER;
        i_sample_in    = '0;
        i_tap_index    = '0;
        i_tap_value    = '0;
        i_block_end_in = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        cur_phase      = -1;
        hold_req       = 1'b0;
        n_errors       = 0;
        n_results      = 0;
        n_samples      = 0;
        n_loads        = 0;

        // Predictor comes out of reset with both stores clear and full length.
        for (i = 0; i < NTAP; i++) begin
            delay_line[i] = '0;
            coef_bank[i]  = '0;
        end
        wr_pos  = 0;
        tap_cfg = fcd_pkg::TAP_COUNT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table from the reset tap_count on; the block's clearing
        // pass simply shows up as a long wait for the first ready.
        for (i = 0; i < N_DIR; i++) begin
            r = dir_tab[i];
            if (r.kind == ROW_TAPS) begin
                settle();
                write_taps(fcd_pkg::CFG_W'(r.val));
            end else begin
                it.op   = (r.kind == ROW_LOAD) ? fcd_pkg::OP_LOAD : fcd_pkg::OP_FILTER;
                it.smp  = (r.kind == ROW_FILTER) ? SW'(r.val) : '0;
                it.coef = (r.kind == ROW_LOAD) ? CW'(r.val) : '0;
                it.idx  = r.idx;
                it.be   = r.be;
                offer_item(it, r.chk, r.want);
            end
        end

        // Random phases: quiesce, set tap_count, refresh the active coefficients,
        // then mixed loads and samples under the phase's idling pattern.
        for (p = 0; p < N_PHASE; p++) begin
            ph = phase_tab[p];
            settle();
            write_taps(fcd_pkg::CFG_W'(ph.taps));
            set_idle(ph.mode);
            cur_phase = p;
            hold_req  = ph.pressure;
            n = taps_in_use(fcd_pkg::CFG_W'(ph.taps));
            for (i = 0; i < int'(n); i++) begin
                it.op   = fcd_pkg::OP_LOAD;
                it.idx  = fcd_pkg::IDX_W'(i);
                it.coef = CW'(pick_word());
                it.smp  = SW'($urandom);
                it.be   = 1'($urandom_range(1));
                offer_item(it, 1'b0, 0);
            end
            for (i = 0; i < ph.count; i++)
                offer_item(random_item(n), 1'b0, 0);
            hold_req = 1'b0;
        end

        settle();

        $display("covered %0d samples and %0d coefficient loads over %0d tap settings",
                 n_samples, n_loads, N_PHASE + 4);
        $display("checked %0d results with four idling patterns and one long output stall",
                 n_results);
        if (n_errors == 0) begin
            $display("fir_filter_circular_delay regression: pass");
        end else begin
            $display("%0d mismatching results", n_errors);
            $display("fir_filter_circular_delay regression: fail");
        end
        $finish;
    end

endmodule
